@@ rtl/qst_pkg.sv @@
// Shared types, constants and helpers for the quartic swing trajectory block.
package qst_pkg;

	localparam int ACC_W    = 48;
	localparam int PROD_W   = 64;
	localparam int DVS_W    = 24;
	localparam int POS_W    = 32;
	localparam int NUM_AXES = 3;
	localparam int NUM_COEF = 5;
	localparam int COEF_AW  = 4;
	localparam int STEP_W   = 3;
	localparam int IDX_W    = 9;

	localparam logic [DVS_W-1:0] US_PER_S = 24'd1000000;
	localparam logic [DVS_W-1:0] DUR_MIN  = 24'd1000;
	localparam logic [DVS_W-1:0] DUR_MAX  = 24'd10000000;

	localparam logic signed [ACC_W-1:0] DERIV_LIM = 48'sd4398046511104;

	localparam logic signed [ACC_W-1:0] K2  = 48'sd2;
	localparam logic signed [ACC_W-1:0] K3  = 48'sd3;
	localparam logic signed [ACC_W-1:0] K4  = 48'sd4;
	localparam logic signed [ACC_W-1:0] K5  = 48'sd5;
	localparam logic signed [ACC_W-1:0] K8  = 48'sd8;
	localparam logic signed [ACC_W-1:0] K11 = 48'sd11;
	localparam logic signed [ACC_W-1:0] K14 = 48'sd14;
	localparam logic signed [ACC_W-1:0] K16 = 48'sd16;
	localparam logic signed [ACC_W-1:0] K18 = 48'sd18;
	localparam logic signed [ACC_W-1:0] K32 = 48'sd32;

	localparam logic       ACT_LOAD = 1'b0;
	localparam logic       ACT_TICK = 1'b1;
	localparam logic [1:0] AX_LAST  = 2'd2;
	localparam logic [1:0] AX_NONE  = 2'd3;

	localparam logic [STEP_W-1:0] COEF_LAST = 3'd4;
	localparam logic [STEP_W-1:0] POS_LAST  = 3'd3;
	localparam logic [STEP_W-1:0] VEL_LAST  = 3'd2;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_LD_MUL,
		DP_LD_TV,
		DP_COEF_WR,
		DP_ACC_INIT,
		DP_TK_MUL,
		DP_ACC_ADD,
		DP_VEL_MUL,
		DP_POS_ST,
		DP_VEL_ST,
		DP_OUT_WRITE
	} dp_op_t;

	typedef enum logic [1:0] {
		DS_US,
		DS_SAMP,
		DS_DUR
	} div_sel_t;

	typedef struct packed {
		dp_op_t              op;
		logic [1:0]          axis;
		logic [STEP_W-1:0]   step;
		logic                vel;
		logic                tvsel;
		div_sel_t            dsel;
		logic                div_start;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_block;
	} sts_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi)
			return 32'sh7FFFFFFF;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[POS_W-1:0];
	endfunction

endpackage

@@ rtl/qst_div.sv @@
// Iterative rounding divider: floor((x + d/2) / d), four quotient bits per cycle.
module qst_div import qst_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PROD_W-1:0] dividend,
	input  logic [DVS_W-1:0]         divisor,
	output logic                     busy,
	output logic                     done,
	output logic signed [PROD_W-1:0] quotient
);

	localparam int RADIX_BITS = 4;
	localparam int ITER       = PROD_W / RADIX_BITS;
	localparam int CNT_W      = $clog2(ITER);

	logic [DVS_W:0]       rem_q, rem_n;
	logic [PROD_W-1:0]    quo_q, quo_n;
	logic [DVS_W-1:0]     dvs_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;
	logic signed [PROD_W-1:0] y;

	assign y = dividend + PROD_W'(divisor >> 1);

	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < RADIX_BITS; i++) begin
			rem_n = {rem_n[DVS_W-1:0], quo_n[PROD_W-1]};
			quo_n = {quo_n[PROD_W-2:0], 1'b0};
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_n = rem_n - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= y[PROD_W-1];
			quo_q <= y[PROD_W-1] ? ~y : y;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? ~quo_q : quo_q;

endmodule

@@ rtl/qst_dp.sv @@
// Datapath: coefficient store, shared multiplier and divider, sample counter, result registers.
module qst_dp import qst_pkg::*; #(
	parameter int SAMPLES = 334
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [1:0]              axis,
	input  logic signed [31:0]      start_position,
	input  logic signed [31:0]      mid_position,
	input  logic signed [31:0]      end_position,
	input  logic signed [31:0]      start_velocity,
	input  logic signed [31:0]      end_velocity,
	input  logic [23:0]             swing_duration_us,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      vel_z,
	output logic [IDX_W-1:0]        sample_index,
	output logic                    last_sample
);

	localparam int KW = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(SAMPLES - 1);

	logic signed [31:0]       p0_q, pm_q, p1_q, v0_q, v1_q;
	logic [DVS_W-1:0]         dur_q;
	logic [1:0]               ld_ax_q;
	logic signed [ACC_W-1:0]  tv0_q, tv1_q;
	logic signed [ACC_W-1:0]  coef_q [NUM_AXES*NUM_COEF];
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [KW-1:0]            k_q;
	logic signed [POS_W-1:0]  pos_q [NUM_AXES];
	logic signed [POS_W-1:0]  vel_q [NUM_AXES];
	logic signed [POS_W-1:0]  opos_q [NUM_AXES];
	logic signed [POS_W-1:0]  ovel_q [NUM_AXES];
	logic [IDX_W-1:0]         oidx_q;
	logic                     olast_q;
	logic                     oval_q;

	logic [DVS_W-1:0]         dur_sat;
	logic [COEF_AW-1:0]       rd_addr, wr_addr;
	logic [STEP_W-1:0]        rd_idx;
	logic signed [ACC_W-1:0]  rq, term, acc_clamp, coef_new;
	logic signed [ACC_W-1:0]  p0e, pme, p1e;
	logic signed [ACC_W-1:0]  mul_a;
	logic [DVS_W-1:0]         mul_b;
	logic signed [ACC_W+DVS_W:0] prod_full;
	logic [DVS_W-1:0]         dvs;
	logic                     div_busy, div_done;
	logic signed [PROD_W-1:0] div_q;
	logic                     k_last;

	assign dur_sat = (swing_duration_us < DUR_MIN) ? DUR_MIN :
		(swing_duration_us > DUR_MAX) ? DUR_MAX : swing_duration_us;

	assign rd_idx  = (cmd.op == DP_ACC_INIT) ? '0 : STEP_W'(cmd.step + 1'b1);
	assign rd_addr = COEF_AW'(cmd.axis) * COEF_AW'(NUM_COEF) + COEF_AW'(rd_idx);
	assign wr_addr = COEF_AW'(ld_ax_q) * COEF_AW'(NUM_COEF) + COEF_AW'(cmd.step);
	assign rq      = coef_q[rd_addr];

	always_comb begin
		term = rq;
		if (cmd.vel) begin
			case (cmd.step)
				3'd0:    term = K3 * rq;
				3'd1:    term = K2 * rq;
				default: term = rq;
			endcase
		end
	end

	assign acc_clamp = (acc_q > DERIV_LIM) ? DERIV_LIM :
		(acc_q < -DERIV_LIM) ? -DERIV_LIM : acc_q;

	assign p0e = ACC_W'(p0_q);
	assign pme = ACC_W'(pm_q);
	assign p1e = ACC_W'(p1_q);

	always_comb begin
		case (cmd.step)
			3'd0: coef_new = -K2 * (tv0_q - tv1_q + K4 * p0e + K4 * p1e - K8 * pme);
			3'd1: coef_new = K5 * tv0_q - K3 * tv1_q + K18 * p0e + K14 * p1e - K32 * pme;
			3'd2: coef_new = -(K4 * tv0_q - tv1_q + K11 * p0e + K5 * p1e - K16 * pme);
			3'd3: coef_new = tv0_q;
			default: coef_new = p0e;
		endcase
	end

	always_comb begin
		mul_a = acc_q;
		mul_b = DVS_W'(k_q);
		case (cmd.op)
			DP_LD_MUL: begin
				mul_a = cmd.tvsel ? ACC_W'(v1_q) : ACC_W'(v0_q);
				mul_b = dur_q;
			end
			DP_VEL_MUL: begin
				mul_a = acc_clamp;
				mul_b = US_PER_S;
			end
			default: begin
				mul_a = acc_q;
				mul_b = DVS_W'(k_q);
			end
		endcase
	end

	assign prod_full = mul_a * $signed({1'b0, mul_b});

	always_comb begin
		case (cmd.dsel)
			DS_US:   dvs = US_PER_S;
			DS_SAMP: dvs = DVS_W'(SAMPLES);
			DS_DUR:  dvs = dur_q;
			default: dvs = dur_q;
		endcase
	end

	qst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign k_last = (k_q == K_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q  <= DUR_MIN;
			k_q    <= '0;
			oval_q <= 1'b0;
			for (int i = 0; i < NUM_AXES*NUM_COEF; i++)
				coef_q[i] <= '0;
		end else begin
			case (cmd.op)
				DP_CAPTURE: begin
					dur_q <= dur_sat;
					k_q   <= '0;
				end
				DP_COEF_WR:   coef_q[wr_addr] <= coef_new;
				DP_OUT_WRITE: k_q <= k_last ? K_LAST : KW'(k_q + 1'b1);
				default: ;
			endcase
			if (cmd.op == DP_OUT_WRITE)
				oval_q <= 1'b1;
			else if (!out_stall)
				oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_CAPTURE: begin
				ld_ax_q <= axis;
				p0_q    <= start_position;
				pm_q    <= mid_position;
				p1_q    <= end_position;
				v0_q    <= start_velocity;
				v1_q    <= end_velocity;
			end
			DP_LD_MUL, DP_TK_MUL, DP_VEL_MUL: prod_q <= prod_full[PROD_W-1:0];
			DP_LD_TV: begin
				if (cmd.tvsel)
					tv1_q <= div_q[ACC_W-1:0];
				else
					tv0_q <= div_q[ACC_W-1:0];
			end
			DP_ACC_INIT: acc_q <= cmd.vel ? (rq <<< 2) : rq;
			DP_ACC_ADD:  acc_q <= div_q[ACC_W-1:0] + term;
			DP_POS_ST:   pos_q[cmd.axis] <= sat32(PROD_W'(acc_q));
			DP_VEL_ST:   vel_q[cmd.axis] <= sat32(div_q);
			DP_OUT_WRITE: begin
				opos_q  <= pos_q;
				ovel_q  <= vel_q;
				oidx_q  <= IDX_W'(k_q);
				olast_q <= k_last;
			end
			default: ;
		endcase
	end

	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.out_block = oval_q & out_stall;

	assign out_valid    = oval_q;
	assign pos_x        = opos_q[0];
	assign pos_y        = opos_q[1];
	assign pos_z        = opos_q[2];
	assign vel_x        = ovel_q[0];
	assign vel_y        = ovel_q[1];
	assign vel_z        = ovel_q[2];
	assign sample_index = oidx_q;
	assign last_sample  = olast_q;

endmodule

@@ rtl/qst_ctrl.sv @@
// Controller: sequences loads and ticks through the shared multiplier and divider.
module qst_ctrl import qst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [1:0] axis,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [15:0] {
		S_IDLE      = 16'b0000000000000001,
		S_LD_MUL    = 16'b0000000000000010,
		S_LD_DGO    = 16'b0000000000000100,
		S_LD_DWAIT  = 16'b0000000000001000,
		S_LD_TV     = 16'b0000000000010000,
		S_LD_COEF   = 16'b0000000000100000,
		S_TK_INIT   = 16'b0000000001000000,
		S_TK_MUL    = 16'b0000000010000000,
		S_TK_DGO    = 16'b0000000100000000,
		S_TK_DWAIT  = 16'b0000001000000000,
		S_TK_ADD    = 16'b0000010000000000,
		S_TK_VMUL   = 16'b0000100000000000,
		S_TK_VDGO   = 16'b0001000000000000,
		S_TK_VDWAIT = 16'b0010000000000000,
		S_TK_STORE  = 16'b0100000000000000,
		S_OUT       = 16'b1000000000000000
	} state_t;

	state_t            state_q, state_n;
	logic [1:0]        ax_q, ax_n;
	logic [STEP_W-1:0] step_q, step_n;
	logic              vel_q, vel_n;
	logic              tvsel_q, tvsel_n;

	always_comb begin
		state_n = state_q;
		ax_n    = ax_q;
		step_n  = step_q;
		vel_n   = vel_q;
		tvsel_n = tvsel_q;
		cmd           = '0;
		cmd.op        = DP_NOP;
		cmd.dsel      = DS_SAMP;
		cmd.axis      = ax_q;
		cmd.step      = step_q;
		cmd.vel       = vel_q;
		cmd.tvsel     = tvsel_q;
		cmd.div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (action == ACT_TICK) begin
						ax_n    = '0;
						vel_n   = 1'b0;
						state_n = S_TK_INIT;
					end else if (axis != AX_NONE) begin
						cmd.op  = DP_CAPTURE;
						tvsel_n = 1'b0;
						state_n = S_LD_MUL;
					end
				end
			end
			S_LD_MUL: begin
				cmd.op  = DP_LD_MUL;
				state_n = S_LD_DGO;
			end
			S_LD_DGO: begin
				cmd.dsel      = DS_US;
				cmd.div_start = 1'b1;
				state_n       = S_LD_DWAIT;
			end
			S_LD_DWAIT: begin
				cmd.dsel = DS_US;
				if (sts.div_done)
					state_n = S_LD_TV;
			end
			S_LD_TV: begin
				cmd.op = DP_LD_TV;
				if (!tvsel_q) begin
					tvsel_n = 1'b1;
					state_n = S_LD_MUL;
				end else begin
					step_n  = '0;
					state_n = S_LD_COEF;
				end
			end
			S_LD_COEF: begin
				cmd.op = DP_COEF_WR;
				if (step_q == COEF_LAST)
					state_n = S_IDLE;
				else
					step_n = step_q + 1'b1;
			end
			S_TK_INIT: begin
				cmd.op  = DP_ACC_INIT;
				step_n  = '0;
				state_n = S_TK_MUL;
			end
			S_TK_MUL: begin
				cmd.op  = DP_TK_MUL;
				state_n = S_TK_DGO;
			end
			S_TK_DGO: begin
				cmd.div_start = 1'b1;
				state_n       = S_TK_DWAIT;
			end
			S_TK_DWAIT: begin
				if (sts.div_done)
					state_n = S_TK_ADD;
			end
			S_TK_ADD: begin
				cmd.op = DP_ACC_ADD;
				if (vel_q && step_q == VEL_LAST)
					state_n = S_TK_VMUL;
				else if (!vel_q && step_q == POS_LAST)
					state_n = S_TK_STORE;
				else begin
					step_n  = step_q + 1'b1;
					state_n = S_TK_MUL;
				end
			end
			S_TK_VMUL: begin
				cmd.op  = DP_VEL_MUL;
				state_n = S_TK_VDGO;
			end
			S_TK_VDGO: begin
				cmd.dsel      = DS_DUR;
				cmd.div_start = 1'b1;
				state_n       = S_TK_VDWAIT;
			end
			S_TK_VDWAIT: begin
				cmd.dsel = DS_DUR;
				if (sts.div_done)
					state_n = S_TK_STORE;
			end
			S_TK_STORE: begin
				cmd.op = vel_q ? DP_VEL_ST : DP_POS_ST;
				if (!vel_q) begin
					vel_n   = 1'b1;
					state_n = S_TK_INIT;
				end else if (ax_q == AX_LAST) begin
					state_n = S_OUT;
				end else begin
					ax_n    = ax_q + 1'b1;
					vel_n   = 1'b0;
					state_n = S_TK_INIT;
				end
			end
			S_OUT: begin
				if (!sts.out_block) begin
					cmd.op  = DP_OUT_WRITE;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q    <= '0;
			step_q  <= '0;
			vel_q   <= 1'b0;
			tvsel_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ax_q    <= ax_n;
			step_q  <= step_n;
			vel_q   <= vel_n;
			tvsel_q <= tvsel_n;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ rtl/quartic_swing_trajectory.sv @@
// Three-axis quartic swing trajectory generator, top level.
// Load transaction: two rounding divisions by 1e6, five coefficient writes.
// Tick transaction: 24 divisions share one divider at 4 quotient bits
// per cycle. One transaction at a time.
// A finished sample waits in the output register while the next transaction is taken.
// Reset: coefficients zero, duration 1000 us, sample counter zero, no result pending.
module quartic_swing_trajectory import qst_pkg::*; #(
	parameter int SAMPLES = 334
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [1:0]         axis,
	input  logic signed [31:0] start_position,
	input  logic signed [31:0] mid_position,
	input  logic signed [31:0] end_position,
	input  logic signed [31:0] start_velocity,
	input  logic signed [31:0] end_velocity,
	input  logic [23:0]        swing_duration_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic [8:0]         sample_index,
	output logic               last_sample
);

	cmd_t cmd;
	sts_t sts;

	qst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.axis     (axis),
		.sts      (sts),
		.cmd      (cmd)
	);

	qst_dp #(.SAMPLES(SAMPLES)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.axis              (axis),
		.start_position    (start_position),
		.mid_position      (mid_position),
		.end_position      (end_position),
		.start_velocity    (start_velocity),
		.end_velocity      (end_velocity),
		.swing_duration_us (swing_duration_us),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.vel_x             (vel_x),
		.vel_y             (vel_y),
		.vel_z             (vel_z),
		.sample_index      (sample_index),
		.last_sample       (last_sample)
	);

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.div_busy)
		else $error("ready for a transaction while a division runs");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_OUT_WRITE) |-> !(out_valid && out_stall))
		else $error("pending result overwritten");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_sample) |-> (sample_index == 9'(SAMPLES - 1)))
		else $error("last sample flag with wrong index");

endmodule

@@ test/quartic_swing_trajectory_tb.sv @@
// Self-checking testbench for the quartic swing trajectory generator.
`timescale 1ns / 100ps
module quartic_swing_trajectory_tb;
	import qst_pkg::*;

	localparam int NSAMP = 334;
	localparam longint COEF_MAX = 64'sd140737488355327;
	localparam longint COEF_MIN = -64'sd140737488355328;
	localparam longint VLIM = 64'sd4398046511104;

	typedef struct {
		logic act;
		logic [1:0] ax;
		logic signed [31:0] p0, pm, p1, v0, v1;
		logic [23:0] dur;
	} cmd_item_t;

	typedef struct {
		logic signed [31:0] pos[3];
		logic signed [31:0] vel[3];
		logic [8:0] idx;
		logic last;
	} sample_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic action;
	logic [1:0] axis;
	logic signed [31:0] start_position, mid_position, end_position, start_velocity, end_velocity;
	logic [23:0] swing_duration_us;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic [8:0] sample_index;
	logic last_sample;

	cmd_item_t pending[$];
	sample_t samples_due[$];
	longint coef[15];
	longint dur_q;
	int unsigned k_cnt;
	int errors = 0;
	bit quiet = 0;
	bit hold_rx = 0;
	int in_gap = 0, out_gap = 0;

	quartic_swing_trajectory DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint rnd_div(longint x, longint d);
		longint y, q;
		y = x + d / 2;
		q = y / d;
		if (y % d != 0 && y < 0)
			q--;
		return q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic signed [31:0] to32(longint v);
		return 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
	endfunction

	task automatic predict(cmd_item_t c);
		longint d, p0, pm, p1, t0, t1, cc[5], p, v, k;
		sample_t s;
		if (c.act == ACT_LOAD) begin
			if (c.ax == AX_NONE)
				return;
			d = clip(longint'(c.dur), DUR_MIN, DUR_MAX);
			dur_q = d;
			p0 = c.p0; pm = c.pm; p1 = c.p1;
			t0 = rnd_div(longint'(c.v0) * d, US_PER_S);
			t1 = rnd_div(longint'(c.v1) * d, US_PER_S);
			cc[0] = -2 * (t0 - t1 + 4 * p0 + 4 * p1 - 8 * pm);
			cc[1] = 5 * t0 - 3 * t1 + 18 * p0 + 14 * p1 - 32 * pm;
			cc[2] = -(4 * t0 - t1 + 11 * p0 + 5 * p1 - 16 * pm);
			cc[3] = t0;
			cc[4] = p0;
			for (int j = 0; j < 5; j++)
				coef[c.ax * 5 + j] = clip(cc[j], COEF_MIN, COEF_MAX);
			k_cnt = 0;
			return;
		end
		k = k_cnt;
		for (int a = 0; a < 3; a++) begin
			p = coef[a * 5];
			for (int j = 1; j < 5; j++)
				p = rnd_div(p * k, NSAMP) + coef[a * 5 + j];
			v = 4 * coef[a * 5];
			v = rnd_div(v * k, NSAMP) + 3 * coef[a * 5 + 1];
			v = rnd_div(v * k, NSAMP) + 2 * coef[a * 5 + 2];
			v = rnd_div(v * k, NSAMP) + coef[a * 5 + 3];
			v = clip(v, -VLIM, VLIM);
			v = rnd_div(v * US_PER_S, dur_q);
			s.pos[a] = to32(p);
			s.vel[a] = to32(v);
		end
		s.idx = 9'(k_cnt);
		s.last = k_cnt >= NSAMP - 1;
		if (!s.last)
			k_cnt++;
		samples_due.push_back(s);
	endtask

	function automatic logic signed [31:0] rnd32();
		case ($urandom_range(0, 5))
		0: return 32'sh7FFFFFFF;
		1: return 32'sh80000000;
		2: return 32'($urandom_range(0, 400000)) - 32'sd200000;
		default: return $urandom;
		endcase
	endfunction

	function automatic cmd_item_t mk(logic act, logic [1:0] ax, bit wild);
		cmd_item_t c;
		c.act = act;
		c.ax = ax;
		c.p0 = rnd32(); c.pm = rnd32(); c.p1 = rnd32(); c.v0 = rnd32(); c.v1 = rnd32();
		if (wild)
			c.dur = 24'($urandom);
		else
			c.dur = 24'($urandom_range(DUR_MIN, DUR_MAX));
		return c;
	endfunction

	task automatic add(cmd_item_t c);
		pending.push_back(c);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict(pending.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0)
					in_gap--;
				else if (!quiet && $urandom_range(0, 9) == 0)
					in_gap = $urandom_range(1, 8);
				if (pending.size() > 0 && in_gap == 0) begin
					in_valid <= 1;
					action <= pending[0].act;
					axis <= pending[0].ax;
					start_position <= pending[0].p0;
					mid_position <= pending[0].pm;
					end_position <= pending[0].p1;
					start_velocity <= pending[0].v0;
					end_velocity <= pending[0].v1;
					swing_duration_us <= pending[0].dur;
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			out_stall <= 1;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (samples_due.size() == 0) begin
					$error("unexpected result");
					errors++;
				end else begin
					e = samples_due.pop_front();
					if (pos_x !== e.pos[0]) begin $error("pos_x exp %0d got %0d", e.pos[0], pos_x); errors++; end
					if (pos_y !== e.pos[1]) begin $error("pos_y exp %0d got %0d", e.pos[1], pos_y); errors++; end
					if (pos_z !== e.pos[2]) begin $error("pos_z exp %0d got %0d", e.pos[2], pos_z); errors++; end
					if (vel_x !== e.vel[0]) begin $error("vel_x exp %0d got %0d", e.vel[0], vel_x); errors++; end
					if (vel_y !== e.vel[1]) begin $error("vel_y exp %0d got %0d", e.vel[1], vel_y); errors++; end
					if (vel_z !== e.vel[2]) begin $error("vel_z exp %0d got %0d", e.vel[2], vel_z); errors++; end
					if (sample_index !== e.idx) begin
						$error("sample_index exp %0d got %0d", e.idx, sample_index); errors++;
					end
					if (last_sample !== e.last) begin
						$error("last_sample exp %0d got %0d", e.last, last_sample); errors++;
					end
				end
			end
			if (out_gap > 0)
				out_gap--;
			else if (!quiet && $urandom_range(0, 9) == 0)
				out_gap = $urandom_range(1, 8);
			out_stall <= hold_rx || out_gap > 0;
		end
	end

	initial begin
		cmd_item_t c;
		int hold;
		for (int i = 0; i < 15; i++)
			coef[i] = 0;
		dur_q = DUR_MIN;
		k_cnt = 0;
		arst_n = 0;
		in_valid = 0;
		out_stall = 1;
		action = ACT_LOAD; axis = 0;
		start_position = 0; mid_position = 0; end_position = 0;
		start_velocity = 0; end_velocity = 0; swing_duration_us = DUR_MIN;
		repeat (7) @(posedge clk);
		arst_n = 1;

		// ticks before any load
		add(mk(ACT_TICK, 0, 0));
		add(mk(ACT_TICK, 0, 0));
		// extremes and duration saturation
		c = mk(ACT_LOAD, 0, 0);
		c.p0 = 32'sh7FFFFFFF; c.pm = 32'sh80000000; c.p1 = 32'sh7FFFFFFF;
		c.v0 = 32'sh7FFFFFFF; c.v1 = 32'sh80000000; c.dur = 24'hFFFFFF;
		add(c);
		c = mk(ACT_LOAD, 1, 0);
		c.p0 = 32'sh80000000; c.pm = 32'sh7FFFFFFF; c.p1 = 32'sh80000000;
		c.v0 = 32'sh80000000; c.v1 = 32'sh7FFFFFFF; c.dur = 0;
		add(c);
		add(mk(ACT_LOAD, AX_LAST, 0));
		add(mk(ACT_LOAD, AX_NONE, 0));
		for (int i = 0; i < 4; i++)
			add(mk(ACT_TICK, 0, 0));
		c = mk(ACT_LOAD, 2, 0);
		c.dur = DUR_MIN;
		add(c);
		c = mk(ACT_LOAD, 0, 0);
		c.dur = DUR_MAX;
		add(c);
		for (int i = 0; i < 3; i++)
			add(mk(ACT_TICK, 0, 0));

		// random swings: three loads, then a run of ticks, sometimes past the end, mixed with single random commands
		while (pending.size() < 1350) begin
			if ($urandom_range(0, 9) == 0) begin
				add(mk(1'($urandom_range(0, 1)), 2'($urandom), 1));
				continue;
			end
			for (int a = 0; a < 3; a++)
				add(mk(ACT_LOAD, 2'(a), $urandom_range(0, 7) == 0));
			hold = $urandom_range(0, 19) == 0 ? NSAMP + 3 : $urandom_range(1, 40);
			for (int i = 0; i < hold; i++)
				add(mk(ACT_TICK, 0, 0));
		end

		// long receiver hold-off while input keeps coming
		@(posedge clk);
		hold_rx <= 1;
		repeat (3000) @(posedge clk);
		hold_rx <= 0;

		wait (pending.size() < 60);
		quiet = 1;
		wait (pending.size() == 0 && !in_valid);
		wait (samples_due.size() == 0);
		repeat (1000) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
